### hdl/abe_pkg.sv
// alpha blit engine: shared types, register indexes and item kinds
// no dependencies; used by every module of the block
package abe_pkg;

    localparam int COUNT_W   = 12;   // column/row counter width
    localparam int SIDE_W    = 13;   // rectangle side register width
    localparam int ORIGIN_W  = 12;   // origin register width
    localparam int ADDR_W    = 24;   // framebuffer pixel address width
    localparam int PIXEL_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STRIDE = 3'd6;

    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // what the back end does with an item
    localparam logic [1:0] KIND_SKIP  = 2'd0;   // alpha zero, no write
    localparam logic [1:0] KIND_COPY  = 2'd1;   // alpha full, copy source
    localparam logic [1:0] KIND_BLEND = 2'd2;   // partial alpha, mix channels
    localparam logic [1:0] KIND_EMPTY = 2'd3;   // clipped region is empty

    typedef struct packed {
        logic [SIDE_W-1:0]   source_width;
        logic [SIDE_W-1:0]   source_height;
        logic [SIDE_W-1:0]   target_width;
        logic [SIDE_W-1:0]   target_height;
        logic [ORIGIN_W-1:0] target_left;
        logic [ORIGIN_W-1:0] target_top;
        logic [SIDE_W-1:0]   target_stride;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               last;
        logic [SIDE_W-1:0]  row_sum;     // target_top + row
        logic [SIDE_W-1:0]  col_sum;     // target_left + column
        logic [PIXEL_W-1:0] src;
        logic [23:0]        dst_rgb;
    } job_t;

endpackage

### hdl/abe_front.sv
// alpha blit engine front end: walks the clipped region and classifies pixels
// depends on abe_pkg
module abe_front import abe_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               restart,
    input  logic               in_valid,
    input  logic [PIXEL_W-1:0] source_pixel,
    input  logic [PIXEL_W-1:0] current_pixel,
    input  logic               push_ready,
    output logic               push_valid,
    output job_t               push_job
);

    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [SIDE_W-1:0]  min_w, min_h, draw_w, draw_h;
    logic               empty;
    logic               col_wrap, row_wrap;
    logic [CHAN_W-1:0]  alpha;
    logic               accept;

    always_comb
    begin
        min_w = (cfg.source_width < cfg.target_width) ? cfg.source_width
                                                      : cfg.target_width;
        min_h = (cfg.source_height < cfg.target_height) ? cfg.source_height
                                                        : cfg.target_height;
        draw_w = (32'(min_w) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : min_w;
        draw_h = (32'(min_h) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : min_h;
    end

    assign empty    = (draw_w == '0) || (draw_h == '0);
    assign col_wrap = ({1'b0, col_reg} + 13'd1) >= draw_w;
    assign row_wrap = ({1'b0, row_reg} + 13'd1) >= draw_h;
    assign alpha    = source_pixel[31:24];
    assign accept   = in_valid && push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_job.src     = source_pixel;
        push_job.dst_rgb = current_pixel[23:0];
        push_job.row_sum = {1'b0, cfg.target_top} + {1'b0, row_reg};
        push_job.col_sum = {1'b0, cfg.target_left} + {1'b0, col_reg};
        push_job.last    = empty || (col_wrap && row_wrap);
        if (empty)
            push_job.kind = KIND_EMPTY;
        else if (alpha == ALPHA_CLEAR)
            push_job.kind = KIND_SKIP;
        else if (alpha == ALPHA_OPAQUE)
            push_job.kind = KIND_COPY;
        else
            push_job.kind = KIND_BLEND;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (empty)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_next = col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### hdl/abe_queue.sv
// alpha blit engine: short queue between front end and back end
// depends on abe_pkg
module abe_queue import abe_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/abe_back.sv
// alpha blit engine back end: address multiply, channel blend, output register
// depends on abe_pkg
module abe_back import abe_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SIDE_W-1:0]  target_stride,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  write_address,
    output logic [PIXEL_W-1:0] write_data,
    output logic               write_enable,
    output logic               end_of_region
);

    // exact x/255 for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [16:0] x);
        logic [16:0] t;
        t = x + (x >> 8) + 17'd1;
        return t[15:8];
    endfunction

    // stage 1: products
    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic               s1_last_reg;
    logic [PIXEL_W-1:0] s1_src_reg;
    logic [15:0]        s1_sa_reg [3];
    logic [15:0]        s1_db_reg [3];
    logic [25:0]        s1_row_prod_reg;
    logic [SIDE_W-1:0]  s1_col_sum_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PIXEL_W-1:0] data_reg;
    logic               we_reg;
    logic               last_reg;

    logic              out_load, s1_load;
    logic [CHAN_W-1:0] alpha, alpha_inv;
    logic [CHAN_W-1:0] mix [3];
    logic [ADDR_W-1:0] addr_sum;

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !s1_valid_reg || out_load;
    assign s1_load   = job_valid && job_ready;
    assign alpha     = job.src[31:24];
    assign alpha_inv = ~alpha;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg     <= job.kind;
            s1_last_reg     <= job.last;
            s1_src_reg      <= job.src;
            s1_row_prod_reg <= job.row_sum * target_stride;
            s1_col_sum_reg  <= job.col_sum;
            for (int c = 0; c < 3; c++)
            begin
                s1_sa_reg[c] <= job.src[c*8 +: 8] * alpha;
                s1_db_reg[c] <= job.dst_rgb[c*8 +: 8] * alpha_inv;
            end
        end
    end

    // stage 2: sums and division by 255
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            mix[c] = div255({1'b0, s1_sa_reg[c]} + {1'b0, s1_db_reg[c]});
        addr_sum = s1_row_prod_reg[ADDR_W-1:0] + ADDR_W'(s1_col_sum_reg);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            last_reg <= s1_last_reg;
            case (s1_kind_reg)
                KIND_EMPTY:
                begin
                    addr_reg <= '0;
                    data_reg <= '0;
                    we_reg   <= 1'b0;
                end
                KIND_SKIP:
                begin
                    addr_reg <= addr_sum;
                    data_reg <= '0;
                    we_reg   <= 1'b0;
                end
                KIND_COPY:
                begin
                    addr_reg <= addr_sum;
                    data_reg <= s1_src_reg;
                    we_reg   <= 1'b1;
                end
                default:
                begin
                    addr_reg <= addr_sum;
                    data_reg <= {ALPHA_OPAQUE, mix[2], mix[1], mix[0]};
                    we_reg   <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
                s1_valid_reg <= job_valid;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign write_enable  = we_reg;
    assign end_of_region = last_reg;

endmodule

### hdl/alpha_blit_engine_core.sv
// alpha blit engine top level: register file, front end, queue, back end
// depends on abe_pkg, abe_front, abe_queue, abe_back
// an accepted pixel is stored in the queue, then registered in back end stage 1 and in the output register
// throughput: one pixel per cycle while m_tready stays high, set by the two-stage back end pipeline
// the front end keeps taking pixels while the four-entry queue has room
// reset: registers to their reset values (stride 1), counters to 0, queue and pipe empty
module alpha_blit_engine_core import abe_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // source_pixel[31:0], current_pixel[63:32]
    // write output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // write_address[23:0], write_data[55:24]
    output logic                  m_tuser,   // write_enable
    output logic                  m_tlast    // end_of_region
);

    cfg_t cfg_reg;
    logic restart;
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;
    logic [ADDR_W-1:0]  write_address;
    logic [PIXEL_W-1:0] write_data;

    // any write to a known register restarts the region walk
    assign restart = cfg_we && (cfg_index <= REG_TARGET_STRIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all fields zero except the stride, which is the lowest field
            cfg_reg <= {{(4*SIDE_W + 2*ORIGIN_W){1'b0}}, SIDE_W'(1)};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data;
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data;
                REG_TARGET_WIDTH:  cfg_reg.target_width  <= cfg_data;
                REG_TARGET_HEIGHT: cfg_reg.target_height <= cfg_data;
                REG_TARGET_LEFT:   cfg_reg.target_left   <= cfg_data[ORIGIN_W-1:0];
                REG_TARGET_TOP:    cfg_reg.target_top    <= cfg_data[ORIGIN_W-1:0];
                REG_TARGET_STRIDE: cfg_reg.target_stride <= cfg_data;
                default:           ;   // unknown index, ignored
            endcase
        end
    end

    // front end: counts position in the clipped region, tags each pixel
    abe_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .restart       (restart),
        .in_valid      (s_tvalid),
        .source_pixel  (s_tdata[31:0]),
        .current_pixel (s_tdata[63:32]),
        .push_ready    (push_ready),
        .push_valid    (push_valid),
        .push_job      (push_job)
    );

    // decoupling queue; its free space is the input ready
    abe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    assign s_tready = push_ready;

    // back end: address and blend math, registered output transaction
    abe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_stride (cfg_reg.target_stride),
        .job_valid     (pop_valid),
        .job_ready     (pop_ready),
        .job           (pop_job),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .write_address (write_address),
        .write_data    (write_data),
        .write_enable  (m_tuser),
        .end_of_region (m_tlast)
    );

    assign m_tdata = {write_data, write_address};

endmodule

### sim/abe_checker.sv
// alpha blit engine checker: watches the register port and both pixel channels
// keeps its own copy of the registers and counters and predicts every write transaction
// depends on abe_pkg
`timescale 1ns / 1ps

module abe_checker import abe_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [63:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [55:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    outstanding,
    output int                    errors,
    output int                    checked
);

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PIXEL_W-1:0] data;
        logic               enable;
        logic               region_end;
    } pixel_write_t;

    cfg_t               regs;
    logic [COUNT_W-1:0] col_pos;
    logic [COUNT_W-1:0] row_pos;
    pixel_write_t       pending_writes[$];

    function automatic int unsigned clip_side(input int unsigned a, input int unsigned b);
        int unsigned m;
        m = (a < b) ? a : b;
        return (m > MAX_SIDE) ? MAX_SIDE : m;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] s,
                                                   input logic [CHAN_W-1:0] d,
                                                   input logic [CHAN_W-1:0] a);
        int unsigned sum;
        sum = int'(s) * int'(a) + int'(d) * (255 - int'(a));
        return CHAN_W'(sum / 255);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // next destination write for one source/destination pixel pair
    task automatic predict_pixel(input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] cur);
        int unsigned  dw;
        int unsigned  dh;
        int unsigned  addr;
        logic [7:0]   a;
        pixel_write_t w;
        dw = clip_side(regs.source_width, regs.target_width);
        dh = clip_side(regs.source_height, regs.target_height);
        a  = src[31:24];
        w  = '0;
        if (dw == 0 || dh == 0) begin
            // empty region: nothing written, every pixel ends the region
            col_pos = '0;
            row_pos = '0;
            w.region_end = 1'b1;
        end
        else begin
            addr = (int'(regs.target_top) + int'(row_pos)) * int'(regs.target_stride)
                   + int'(regs.target_left) + int'(col_pos);
            w.address = ADDR_W'(addr);
            if (a == ALPHA_OPAQUE) begin
                w.data   = src;
                w.enable = 1'b1;
            end
            else if (a != ALPHA_CLEAR) begin
                w.data   = {ALPHA_OPAQUE, mix_chan(src[23:16], cur[23:16], a),
                            mix_chan(src[15:8], cur[15:8], a), mix_chan(src[7:0], cur[7:0], a)};
                w.enable = 1'b1;
            end
            if (int'(col_pos) + 1 >= dw) begin
                col_pos = '0;
                if (int'(row_pos) + 1 >= dh) begin
                    row_pos = '0;
                    w.region_end = 1'b1;
                end
                else begin
                    row_pos = row_pos + 1'b1;
                end
            end
            else begin
                col_pos = col_pos + 1'b1;
            end
        end
        pending_writes.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n) begin
        pixel_write_t want;
        logic         restart;
        if (!rst_n) begin
            regs = '0;
            regs.target_stride = SIDE_W'(1);
            col_pos = '0;
            row_pos = '0;
            pending_writes.delete();
            errors = 0;
            checked = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                restart = 1'b1;
                case (cfg_index)
                    REG_SOURCE_WIDTH:  regs.source_width  = cfg_data;
                    REG_SOURCE_HEIGHT: regs.source_height = cfg_data;
                    REG_TARGET_WIDTH:  regs.target_width  = cfg_data;
                    REG_TARGET_HEIGHT: regs.target_height = cfg_data;
                    REG_TARGET_LEFT:   regs.target_left   = cfg_data[ORIGIN_W-1:0];
                    REG_TARGET_TOP:    regs.target_top    = cfg_data[ORIGIN_W-1:0];
                    REG_TARGET_STRIDE: regs.target_stride = cfg_data;
                    default:           restart = 1'b0;
                endcase
                if (restart) begin
                    col_pos = '0;
                    row_pos = '0;
                end
            end
            // compare first, so a result can never match a pixel taken at the same edge
            if (m_tvalid && m_tready) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch("unexpected write transaction", m_tdata[31:0], '0);
                end
                else begin
                    want = pending_writes.pop_front();
                    checked++;
                    if (m_tdata[23:0] !== want.address)
                        report_mismatch("write_address", 32'(m_tdata[23:0]),
                                        32'(want.address));
                    if (m_tdata[55:24] !== want.data)
                        report_mismatch("write_data", m_tdata[55:24], want.data);
                    if (m_tuser !== want.enable)
                        report_mismatch("write_enable", 32'(m_tuser), 32'(want.enable));
                    if (m_tlast !== want.region_end)
                        report_mismatch("end_of_region", 32'(m_tlast),
                                        32'(want.region_end));
                end
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata[31:0], s_tdata[63:32]);
            outstanding <= pending_writes.size();
        end
    end

endmodule

### sim/tb_alpha_blit_engine_core.sv
// alpha blit engine testbench top: clock, reset, register writes and pixel stimulus
// depends on abe_pkg, alpha_blit_engine_core and abe_checker
`timescale 1ns / 1ps

module tb_alpha_blit_engine_core;
    import abe_pkg::*;

    // index past the register list, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PIXELS = 1550;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;   // source_pixel[31:0], current_pixel[63:32]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;          // write_address[23:0], write_data[55:24]
    logic                  m_tuser;          // write_enable
    logic                  m_tlast;          // end_of_region

    int outstanding;
    int errors;
    int checked;

    // idle percentages of the pixel sender and the write receiver
    int tx_idle_pct = 28;
    int rx_idle_pct = 73;

    int pixels_sent;
    int random_sent;
    int reg_writes;
    int settings_used;

    // shadow of the side registers, only used to size each burst of pixels
    int unsigned sw_q, sh_q, tw_q, th_q;

    alpha_blit_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    abe_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .outstanding (outstanding),
        .errors      (errors),
        .checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout: write transactions stopped arriving");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side: random back pressure on the write channel
    always @(posedge clk) begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // one pixel transaction, with random idle cycles in front of it
    task automatic send_pixel(input logic [31:0] src, input logic [31:0] cur);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cur, src};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pixels_sent++;
    endtask

    // stop sending and wait until every predicted write has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // single register write; callers make sure the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_SOURCE_WIDTH:  sw_q = val;
            REG_SOURCE_HEIGHT: sh_q = val;
            REG_TARGET_WIDTH:  tw_q = val;
            REG_TARGET_HEIGHT: th_q = val;
            default: ;
        endcase
    endtask

    task automatic set_region(input logic [12:0] sw, input logic [12:0] sh,
                              input logic [12:0] tw, input logic [12:0] th,
                              input logic [12:0] left, input logic [12:0] top,
                              input logic [12:0] stride);
        drain();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
        write_reg(REG_TARGET_LEFT, left);
        write_reg(REG_TARGET_TOP, top);
        write_reg(REG_TARGET_STRIDE, stride);
        settings_used++;
    endtask

    // mostly tiny sides, sometimes empty, sometimes past the saturation point
    function automatic logic [12:0] rand_side();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 12) return 13'($urandom_range(4000, 8191));
        if (r < 16) return 13'($urandom_range(0, 8191));
        return 13'($urandom_range(1, 8));
    endfunction

    function automatic logic [12:0] rand_stride();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 13'd1;
        return 13'($urandom_range(0, 8191));
    endfunction

    // alpha clear and opaque a quarter of the time each, otherwise any random alpha
    function automatic logic [31:0] rand_pixel();
        logic [7:0] a;
        case ($urandom_range(0, 3))
            0:       a = ALPHA_CLEAR;
            1:       a = ALPHA_OPAQUE;
            default: a = 8'($urandom_range(0, 255));
        endcase
        return {a, 24'($urandom)};
    endfunction

    // three idling regimes over the random part, the last with none at all
    task automatic pick_idling();
        if (random_sent < RANDOM_PIXELS / 3) begin
            tx_idle_pct = 28;
            rx_idle_pct = 73;
        end
        else if (random_sent < 2 * RANDOM_PIXELS / 3) begin
            tx_idle_pct = 73;
            rx_idle_pct = 28;
        end
        else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // new setting, then a burst that mostly covers whole regions
    task automatic random_phase();
        int unsigned dw;
        int unsigned dh;
        int unsigned area;
        int unsigned n;
        drain();
        if (settings_used == 0 || $urandom_range(0, 2) == 0) begin
            set_region(rand_side(), rand_side(), rand_side(), rand_side(),
                       13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                       rand_stride());
        end
        else begin
            // restart the region by rewriting one register only
            case ($urandom_range(0, 3))
                0:       write_reg(REG_TARGET_LEFT, 13'($urandom_range(0, 8191)));
                1:       write_reg(REG_TARGET_TOP, 13'($urandom_range(0, 8191)));
                2:       write_reg(REG_TARGET_STRIDE, rand_stride());
                default: write_reg(REG_SOURCE_WIDTH, rand_side());
            endcase
            settings_used++;
        end
        // occasional write past the register list, counters keep running
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
        dw = (sw_q < tw_q) ? sw_q : tw_q;
        dh = (sh_q < th_q) ? sh_q : th_q;
        if (dw == 0 || dh == 0)
            n = $urandom_range(1, 4);
        else if (dw > 8 || dh > 8)
            n = $urandom_range(1, 30);
        else begin
            area = dw * dh;
            if ($urandom_range(0, 9) < 7)
                n = area * $urandom_range(1, 3);
            else
                n = $urandom_range(1, 2 * area);
        end
        repeat (n) begin
            pick_idling();
            // now and then hold the stream until the block is empty
            if ($urandom_range(0, 49) == 0)
                drain();
            send_pixel(rand_pixel(), $urandom);
            random_sent++;
        end
    endtask

    initial begin
        pixels_sent   = 0;
        random_sent   = 0;
        reg_writes    = 0;
        settings_used = 0;
        sw_q = 0;
        sh_q = 0;
        tw_q = 0;
        th_q = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values give an empty region
        send_pixel(32'h80FF00FF, 32'h12345678);
        send_pixel(32'hFFFFFFFF, 32'h00000000);

        // 3x2 region clipped by the source: every alpha class and channel extremes
        set_region(13'd3, 13'd2, 13'd5, 13'd2, 13'd5, 13'd7, 13'd20);
        send_pixel({ALPHA_CLEAR, 24'hFFFFFF}, 32'hFFFFFFFF);
        send_pixel({ALPHA_OPAQUE, 24'h000000}, 32'hFFFFFFFF);
        send_pixel({8'h01, 24'hFFFFFF}, 32'h00000000);
        send_pixel({8'hFE, 24'h000000}, 32'hFFFFFFFF);
        send_pixel({8'h80, 24'hFF00FF}, 32'h0000FF00);
        send_pixel({8'h7F, 24'h000000}, 32'hFFFFFFFF);

        // ignored index mid-region: the walk must carry on where it was
        send_pixel(32'hFF123456, 32'h0);
        send_pixel(32'h40ABCDEF, 32'h00FEDCBA);
        drain();
        write_reg(REG_UNUSED, 13'h1FFF);
        send_pixel(32'hC0FFFFFF, 32'h00000000);
        send_pixel(32'h00FFFFFF, 32'hFFFFFFFF);
        send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_pixel(32'h01000000, 32'hFFFFFFFF);

        // zero target height: empty region although the rest is set
        set_region(13'd2, 13'd2, 13'd2, 13'd0, 13'd1, 13'd1, 13'd8);
        send_pixel(32'hFFFFFFFF, 32'h0);

        // origin at the far corner, widest stride: address wraps, bit 12 of left is dropped
        set_region(13'd2, 13'd2, 13'd2, 13'd2, 13'h1FFF, 13'h0FFF, 13'h1FFF);
        send_pixel(32'hFF000000, 32'h0);
        send_pixel(32'h80FFFFFF, 32'h00FFFFFF);
        send_pixel(32'hFFFFFFFF, 32'h0);
        send_pixel(32'h55AA55AA, 32'hAA55AA55);

        // oversized sides saturate, stride of zero is used as is
        set_region(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd4096, 13'd0, 13'h0FFF, 13'd0);
        send_pixel(32'hFFFFFFFF, 32'h0);
        send_pixel(32'h80808080, 32'h7F7F7F7F);
        send_pixel(32'h00000000, 32'hFFFFFFFF);

        while (random_sent < RANDOM_PIXELS)
            random_phase();

        drain();
        // a few more cycles so that a stray late transaction is caught
        repeat (8) @(posedge clk);

        $display("covered %0d pixels, %0d write transactions checked", pixels_sent, checked);
        $display("over %0d register settings and %0d register writes", settings_used, reg_writes);
        if (errors == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/abe_pkg.sv
hdl/abe_front.sv
hdl/abe_queue.sv
hdl/abe_back.sv
hdl/alpha_blit_engine_core.sv
sim/abe_checker.sv
sim/tb_alpha_blit_engine_core.sv
